>>> rtl/pli_pkg.sv
// shared types and constants of the piecewise linear interpolator
package pli_pkg;

  localparam int DATA_W     = 32;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int S_TDATA_W  = 72;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 32;
  localparam int M_TUSER_W  = 2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EMPTY       = 2'd1,
    STATUS_NO_INTERVAL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_CHK0,
    S_CHKL,
    S_SCAN,
    S_MAG,
    S_MUL,
    S_DIV,
    S_LERP,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_ONE,
    ADDR_INC
  } addr_op_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_EMPTY,
    RES_RD_Y,
    RES_PREV_Y,
    RES_NO_INTERVAL,
    RES_LERP
  } res_sel_t;

  typedef struct packed {
    logic     wr_entry;
    logic     capture;
    addr_op_t addr_op;
    logic     prev_load;
    logic     prep_load;
    logic     mag_load;
    logic     mul_load;
    logic     div_step;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic le_first;
    logic ge_last;
    logic in_interval;
    logic zero_width;
    logic scan_end;
    logic div_last;
  } dp_status_t;

endpackage

>>> rtl/pli_ram.sv
// generic single-write, single-read ram with registered read data
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pli_datapath.sv
// breakpoint table, scan compare, multiply and bit-serial divide datapath
module pli_datapath
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [DATA_W-1:0]  x_value,
  input  logic [DATA_W-1:0]  y_value,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         stat,
  output logic [DATA_W-1:0]  y_result,
  output status_t            status
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  logic [NW-1:0]            count;
  logic [NW-1:0]            addr;
  logic                     ram_we;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;
  logic signed [DATA_W-1:0] xq;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic [DATA_W-1:0]        span;
  logic [DATA_W-1:0]        off;
  logic [DATA_W:0]          dy;
  logic [DATA_W:0]          dy_neg;
  logic [DATA_W-1:0]        mag;
  logic                     neg;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DATA_W:0]          trial;
  logic                     q_bit;
  logic [DATA_W:0]          span_w;
  logic [DATA_W:0]          off_w;
  logic [DATA_W-1:0]        res_y;
  status_t                  res_status;

  // point count register, saturated to capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > 32'(MAX_POINTS)) begin
        count <= NW'(MAX_POINTS);
      end else begin
        count <= NW'(cfg_wdata);
      end
    end
  end

  assign ram_we = cmd.wr_entry && (32'(entry_index) < 32'(MAX_POINTS));

  pli_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IW'(entry_index)),
    .wdata({y_value, x_value}),
    .raddr(addr[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_x = ram_rdata[DATA_W-1:0];
  assign rd_y = ram_rdata[2*DATA_W-1:DATA_W];

  // table read address
  always_ff @(posedge clk) begin
    case (cmd.addr_op)
      ADDR_ZERO: addr <= '0;
      ADDR_LAST: addr <= count - NW'(1);
      ADDR_ONE:  addr <= NW'(1);
      ADDR_INC:  addr <= addr + NW'(1);
      default:   addr <= addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xq <= x_value;
    end
    if (cmd.prev_load) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  // interval operands
  assign span_w = {rd_x[DATA_W-1], rd_x} - {prev_x[DATA_W-1], prev_x};
  assign off_w  = {xq[DATA_W-1], xq} - {prev_x[DATA_W-1], prev_x};
  assign dy_neg = (DATA_W+1)'(0) - dy;

  always_ff @(posedge clk) begin
    if (cmd.prep_load) begin
      span <= span_w[DATA_W-1:0];
      off  <= off_w[DATA_W-1:0];
      dy   <= {rd_y[DATA_W-1], rd_y} - {prev_y[DATA_W-1], prev_y};
    end
    if (cmd.mag_load) begin
      neg <= dy[DATA_W];
      mag <= dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
    end
  end

  // restoring divide, one quotient bit per cycle; the quotient fits in one word
  assign trial = {rem, quo[DATA_W-1]};
  assign q_bit = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      {rem, quo} <= (2*DATA_W)'(off) * (2*DATA_W)'(mag);
      div_cnt    <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem     <= q_bit ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
      quo     <= {quo[DATA_W-2:0], q_bit};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      RES_ZERO: begin
        res_y      <= '0;
        res_status <= STATUS_OK;
      end
      RES_EMPTY: begin
        res_y      <= '0;
        res_status <= STATUS_EMPTY;
      end
      RES_RD_Y: begin
        res_y      <= rd_y;
        res_status <= STATUS_OK;
      end
      RES_PREV_Y: begin
        res_y      <= prev_y;
        res_status <= STATUS_OK;
      end
      RES_NO_INTERVAL: begin
        res_y      <= '0;
        res_status <= STATUS_NO_INTERVAL;
      end
      RES_LERP: begin
        res_y      <= neg ? prev_y - quo : prev_y + quo;
        res_status <= STATUS_OK;
      end
      default: begin
        res_y      <= res_y;
        res_status <= res_status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      y_result <= res_y;
      status   <= res_status;
    end
  end

  assign stat.n_zero      = count == '0;
  assign stat.le_first    = xq <= rd_x;
  assign stat.ge_last     = xq >= rd_x;
  assign stat.in_interval = (xq >= prev_x) && (xq <= rd_x);
  assign stat.zero_width  = prev_x == rd_x;
  assign stat.scan_end    = addr == count;
  assign stat.div_last    = div_cnt == '0;

endmodule

>>> rtl/pli_controller.sv
// sequencing state machine: table scan, divide and result handoff
module pli_controller
  import pli_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_mode,
  input  logic       out_ready,
  input  dp_status_t stat,
  output logic       in_ready,
  output logic       out_valid,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD || stat.n_zero) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_RD0;
          end
        end
      end
      S_RD0:  state_next = S_CHK0;
      S_CHK0: state_next = stat.le_first ? S_FINISH : S_CHKL;
      S_CHKL: state_next = stat.ge_last ? S_FINISH : S_SCAN;
      S_SCAN: begin
        if (stat.in_interval) begin
          state_next = stat.zero_width ? S_FINISH : S_MAG;
        end else if (stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_MAG: state_next = S_MUL;
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_last) begin
          state_next = S_LERP;
        end
      end
      S_LERP: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{wr_entry: 1'b0, capture: 1'b0, addr_op: ADDR_HOLD, prev_load: 1'b0,
            prep_load: 1'b0, mag_load: 1'b0, mul_load: 1'b0, div_step: 1'b0,
            res_sel: RES_HOLD, out_load: 1'b0};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            cmd.wr_entry = 1'b1;
            cmd.res_sel  = RES_ZERO;
          end else begin
            cmd.capture = 1'b1;
            if (stat.n_zero) begin
              cmd.res_sel = RES_EMPTY;
            end else begin
              cmd.addr_op = ADDR_ZERO;
            end
          end
        end
      end
      S_RD0: cmd.addr_op = ADDR_LAST;
      S_CHK0: begin
        if (stat.le_first) begin
          cmd.res_sel = RES_RD_Y;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.addr_op   = ADDR_ONE;
        end
      end
      S_CHKL: begin
        if (stat.ge_last) begin
          cmd.res_sel = RES_RD_Y;
        end else begin
          cmd.addr_op = ADDR_INC;
        end
      end
      S_SCAN: begin
        if (stat.in_interval) begin
          if (stat.zero_width) begin
            cmd.res_sel = RES_PREV_Y;
          end else begin
            cmd.prep_load = 1'b1;
          end
        end else begin
          cmd.prev_load = 1'b1;
          if (stat.scan_end) begin
            cmd.res_sel = RES_NO_INTERVAL;
          end else begin
            cmd.addr_op = ADDR_INC;
          end
        end
      end
      S_MAG:    cmd.mag_load = 1'b1;
      S_MUL:    cmd.mul_load = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_LERP:   cmd.res_sel  = RES_LERP;
      S_FINISH: cmd.out_load = out_free;
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/piecewise_linear_interpolator_unit.sv
// top level of the piecewise linear interpolator: controller, datapath, stream ports
//
// usage
//   s_axis carries requests: tuser[0] is the mode (0 load, 1 query); a load
//   writes (x_value, y_value) into breakpoint slot entry_index, a query asks
//   for y at x_value. m_axis returns exactly one result per request: y_result
//   in Q16.16 and a status (0 ok, 1 empty table, 2 no interval found).
//   cfg_we/cfg_wdata set the number of breakpoints in use; write it only while
//   no request is in flight. counts above MAX_POINTS saturate.
// timing
//   one request is worked on at a time; s_axis_tready is high only while the
//   sequencer is idle. a load or a query on an empty table is staged at
//   acceptance and then moved to the output register. a query outside the
//   table ends after the first or last breakpoint read. an interior query scans
//   one breakpoint per cycle through the single table read port, then takes
//   a magnitude step, a multiply and a bit-serial divide.
// reset and stall
//   rst (synchronous) clears the sequencer, the output valid and the point
//   count; table contents are undefined until loaded. the finished result sits
//   in an output register; the next request can be taken while it waits, and
//   a following result holds in its final state until m_axis_tready frees it.
module piecewise_linear_interpolator_unit
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // point count register
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] entry_index, [35:4] x_value, [67:36] y_value, [71:68] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] y_result
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;
  status_t    status;

  // sequencer: owns the handshakes and steps the datapath
  pli_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser[0]),
    .out_ready(m_axis_tready),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .cmd      (cmd)
  );

  // breakpoint table, compares, multiplier, divider and result registers
  pli_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .entry_index(s_axis_tdata[INDEX_W-1:0]),
    .x_value    (s_axis_tdata[INDEX_W+DATA_W-1:INDEX_W]),
    .y_value    (s_axis_tdata[INDEX_W+2*DATA_W-1:INDEX_W+DATA_W]),
    .cmd        (cmd),
    .stat       (stat),
    .y_result   (m_axis_tdata),
    .status     (status)
  );

  assign m_axis_tuser = status;

endmodule

>>> verif/piecewise_linear_interpolator_unit_tb.sv
// self-checking stream testbench for the piecewise linear interpolator unit
`timescale 1ns / 100ps

module piecewise_linear_interpolator_unit_tb;
  import pli_pkg::*;

  localparam int MAX_POINTS = 16;

  // one request as it travels on s_axis
  typedef struct packed {
    logic               mode;
    logic [3:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } request_t;

  // one result as it should come back on m_axis
  typedef struct packed {
    logic [31:0] y;
    status_t     status;
  } answer_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata     = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [3:0] entry_index, [35:4] x_value, [67:36] y_value, [71:68] zero
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // [0] mode
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [31:0] y_result
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [M_TUSER_W-1:0] m_axis_tuser;

  piecewise_linear_interpolator_unit #(
    .MAX_POINTS(MAX_POINTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // requests waiting to be sent, results still owed by the block
  request_t request_q[$];
  answer_t  answer_q[$];

  // breakpoint table and point count as the block should hold them
  int           bp_x [MAX_POINTS];
  int           bp_y [MAX_POINTS];
  logic [4:0]   point_count_now = '0;

  // table as the stimulus plan sees it, in request order
  int           plan_x [MAX_POINTS];
  int           plan_y [MAX_POINTS];

  logic         stall_on = 1'b1;
  int           fault_count = 0;

  // sender state
  logic         feed_busy = 1'b0;
  int           feed_hold = 0;
  request_t     feed_req;

  // receiver state
  int           sink_hold = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // one segment of the interpolation, quotient truncated toward zero
  function automatic logic [31:0] interp_segment(int x, int xa, int ya, int xb, int yb);
    logic [63:0] span;
    logic [63:0] off;
    logic [63:0] mag;
    logic [63:0] quo;
    longint      dy;
    longint      r;
    span = 64'(longint'(xb) - longint'(xa));
    off  = 64'(longint'(x) - longint'(xa));
    dy   = longint'(yb) - longint'(ya);
    mag  = (dy < 0) ? 64'(-dy) : 64'(dy);
    // product stays below 2^64, quotient at most the y step
    quo  = (off * mag) / span;
    r    = (dy < 0) ? longint'(ya) - longint'(quo) : longint'(ya) + longint'(quo);
    return r[31:0];
  endfunction

  // result of one request, updating the table copy on a load
  function automatic answer_t compute_answer(request_t r);
    answer_t a;
    int      n;
    int      i;
    logic    hit;
    a.y      = '0;
    a.status = STATUS_OK;
    if (r.mode == MODE_LOAD) begin
      if (int'(r.slot) < MAX_POINTS) begin
        bp_x[r.slot] = r.x;
        bp_y[r.slot] = r.y;
      end
    end else begin
      // counts above capacity saturate
      n = (int'(point_count_now) > MAX_POINTS) ? MAX_POINTS : int'(point_count_now);
      if (n == 0) begin
        a.status = STATUS_EMPTY;
      end else if (r.x <= bp_x[0]) begin
        a.y = bp_y[0];
      end else if (r.x >= bp_x[n-1]) begin
        a.y = bp_y[n-1];
      end else begin
        // first interval that holds x wins
        hit = 1'b0;
        for (i = 0; i + 1 < n; i++) begin
          if (!hit && r.x >= bp_x[i] && r.x <= bp_x[i+1]) begin
            hit = 1'b1;
            if (bp_x[i] == bp_x[i+1]) a.y = bp_y[i];
            else a.y = interp_segment(r.x, bp_x[i], bp_y[i], bp_x[i+1], bp_y[i+1]);
          end
        end
        if (!hit) a.status = STATUS_NO_INTERVAL;
      end
    end
    return a;
  endfunction

  task automatic log_fault(input string what, input answer_t want);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%t %s: expected y=%h status=%0d, got y=%h status=%0d", $realtime, what,
               want.y, want.status, m_axis_tdata, m_axis_tuser);
    end
  endtask

  // sender: one request on the bus at a time, random gap after each while stalls are on
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      feed_busy = 1'b0;
      feed_hold = 0;
    end else begin
      // request taken at this edge: work out its result now
      if (feed_busy && s_axis_tready) begin
        answer_q.push_back(compute_answer(feed_req));
        feed_busy = 1'b0;
        feed_hold = stall_on ? $urandom_range(0, 10) : 0;
      end
      if (!feed_busy) begin
        if (feed_hold > 0) begin
          feed_hold--;
        end else if (request_q.size() != 0) begin
          feed_req  = request_q.pop_front();
          feed_busy = 1'b1;
        end
      end
      // valid stays high across back-to-back requests, one assignment per edge
      s_axis_tvalid <= feed_busy;
      if (feed_busy) begin
        s_axis_tdata <= {4'b0, feed_req.y, feed_req.x, feed_req.slot};
        s_axis_tuser <= feed_req.mode;
      end
    end
  end

  // receiver: compare each result with the oldest one owed, random stall after while stalls are on
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          want = '0;
          log_fault("result with no request outstanding", want);
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tdata !== want.y || m_axis_tuser !== want.status)
            log_fault("result mismatch", want);
        end
        sink_hold = stall_on ? $urandom_range(0, 10) : 0;
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      m_axis_tready <= (sink_hold == 0);
    end
  end

  task automatic push_load(input int slot, input int x, input int y);
    request_t r;
    r.mode = MODE_LOAD;
    r.slot = 4'(slot);
    r.x    = x;
    r.y    = y;
    request_q.push_back(r);
    plan_x[slot] = x;
    plan_y[slot] = y;
  endtask

  task automatic push_query(input int x, input int y);
    request_t r;
    r.mode = MODE_QUERY;
    r.slot = 4'($urandom_range(0, 15));
    r.x    = x;
    r.y    = y;
    request_q.push_back(r);
  endtask

  // block idle: nothing queued, nothing on the bus, no result owed
  task automatic await_idle();
    while (request_q.size() != 0 || feed_busy || answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [4:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    point_count_now = value;
  endtask

  // load a table for the count in use, then mostly queries with some stray loads
  task automatic run_phase(input logic [4:0] count, input int len, input logic mid_pause);
    int     n;
    int     k;
    int     sel;
    int     xq;
    longint lo;
    longint step_max;
    longint xv;
    longint span;
    logic   narrow;
    logic   unsorted;
    await_idle();
    write_point_count(count);
    n        = (int'(count) > MAX_POINTS) ? MAX_POINTS : int'(count);
    narrow   = ($urandom_range(0, 2) == 0);
    unsorted = ($urandom_range(0, 6) == 0);
    if (narrow) begin
      lo       = (longint'($urandom_range(0, 4000)) - 2000) * 256;
      step_max = longint'($urandom_range(1, 1 << 18));
    end else begin
      lo       = -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
      step_max = (n > 0) ? (64'sd2147483647 - lo) / n : 1;
    end
    // ascending breakpoints, now and then a repeated x; in an unsorted phase x is random
    xv = lo;
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 9) != 0)
        xv += longint'($urandom_range(0, 32'(step_max)));
      push_load(k, unsorted ? int'($urandom) : int'(xv),
                $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 2000)) - 1000);
    end
    for (k = 0; k < len; k++) begin
      if (mid_pause && k == len / 2) await_idle();
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // stray load, may leave the table unsorted
        push_load($urandom_range(0, 15), $urandom, $urandom);
      end else begin
        if (n == 0) begin
          xq = $urandom;
        end else if (sel < 62) begin
          span = longint'(plan_x[n-1]) - longint'(plan_x[0]);
          if (span > 0)
            xq = int'(longint'(plan_x[0]) + longint'($urandom_range(0, 32'(span))));
          else
            xq = $urandom;
        end else if (sel < 77) begin
          xq = plan_x[$urandom_range(0, n - 1)];
        end else if (sel < 87) begin
          xq = $urandom;
        end else begin
          case ($urandom_range(0, 3))
            0:       xq = 32'h8000_0000;
            1:       xq = 32'h7fff_ffff;
            2:       xq = plan_x[0] - 1;
            default: xq = plan_x[n-1] + 1;
          endcase
        end
        push_query(xq, $urandom);
      end
    end
  endtask

  initial begin
    int         ph;
    logic [4:0] count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    push_query(0, 0);
    push_query(32'h8000_0000, 32'h7fff_ffff);
    push_load(0, 32'h8000_0000, 32'h7fff_ffff);
    push_load(15, 32'h7fff_ffff, 32'h8000_0000);

    // single breakpoint: every x maps to its y
    await_idle();
    write_point_count(5'd1);
    push_query(32'h7fff_ffff, 0);
    push_query(32'h8000_0000, 0);

    // four points: full-range step down, a repeated x, then a step down to the minimum y
    push_load(1, 0, 32'h8000_0000);
    push_load(2, 0, 100 << 16);
    push_load(3, 32'h7fff_ffff, 32'h8000_0000);
    await_idle();
    write_point_count(5'd4);
    push_query(32'h8000_0000, 0);
    push_query(32'h7fff_ffff, 0);
    push_query(-1, 0);
    push_query(0, 0);
    push_query(1, 0);
    push_query(32'h4000_0000, 0);
    // out-of-order breakpoint
    push_load(1, 32'h7fff_fff0, 0);
    push_query(5, 0);

    for (ph = 0; ph < 12; ph++) begin
      // even phases idle at random, odd phases run at full rate
      stall_on = !ph[0];
      case (ph)
        0:       count = 5'd2;
        1:       count = 5'd16;
        2:       count = 5'd31;
        3:       count = 5'd17;
        4:       count = 5'd0;
        5:       count = 5'd1;
        6:       count = 5'd3;
        7:       count = 5'd15;
        default: count = 5'($urandom_range(0, 31));
      endcase
      run_phase(count, 30, ph == 2);
    end

    await_idle();
    repeat (64) @(posedge clk);
    if (fault_count == 0 && answer_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_datapath.sv
rtl/pli_controller.sv
rtl/piecewise_linear_interpolator_unit.sv
verif/piecewise_linear_interpolator_unit_tb.sv
